/* rtl/core/tel_pkg.sv */
// ----------------------------------------------------------------------------
// tel_pkg
// Types and codes of the timer event table: operations, result kinds,
// control states and the packed stream layouts.
// ----------------------------------------------------------------------------
package tel_pkg;

   localparam int OP_W       = 2;
   localparam int KIND_W     = 3;
   localparam int TAG_W      = 16;
   localparam int SLOT_W     = 6;
   localparam int DELAY_W    = 32;
   localparam int NOW_W      = 64;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 88;

   typedef enum logic [OP_W-1:0] {
      OP_TICK   = 2'd0,
      OP_ADD    = 2'd1,
      OP_CANCEL = 2'd2
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      K_FIRED  = 3'd0,
      K_NONE   = 3'd1,
      K_ADDED  = 3'd2,
      K_FULL   = 3'd3,
      K_CANCEL = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FLUSH
   } state_type;

   typedef struct packed {
      kind_type          kind;
      logic [TAG_W-1:0]  tag;
      logic [SLOT_W-1:0] slot;
      logic              found;
      logic              last;
   } res_type;

endpackage

/* rtl/core/timer_event_table.sv */
// ----------------------------------------------------------------------------
// timer_event_table
// Millisecond counter with a table of timer event slots kept in one synchronous
// memory and walked one slot per cycle unless a blocked output stalls the walk.
// ----------------------------------------------------------------------------
// Scan: a tick walks every slot and its final item follows the last slot,
//   delayed further by output stalls; an add or cancel stops at its slot.
//   An unknown operation gives no item.
// Flow: one item at a time, the next taken only once the block is idle again
//   (an unknown operation leaves it idle); the slot walk sets the rate.
// Reset: clears the state, counter, valid flags and all active flags at once;
//   the slot memory needs no clearing, as only active slots' contents are used.
module timer_event_table #(
   parameter int SLOT_COUNT = 64,
   parameter int TAG_BITS   = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // event_tag[15:0], delay_ms[47:16], interval[79:48]
   input  logic [tel_pkg::REQ_DATA_W-1:0]  req_tdata,
   // operation[1:0]
   input  logic [tel_pkg::OP_W-1:0]        req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // event_tag_out[15:0], slot_index[21:16], found[22], now_ms[86:23], zero[87]
   output logic [tel_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // result_kind[2:0]
   output logic [tel_pkg::KIND_W-1:0]      rsp_tuser,
   output logic                            rsp_tlast
);
   import tel_pkg::*;

   localparam int IDX_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int ENT_W   = NOW_W + DELAY_W + TAG_BITS;
   localparam int PER_LSB = TAG_BITS;
   localparam int EXP_LSB = TAG_BITS + DELAY_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

   state_type               state_ff, state_in;
   logic [NOW_W-1:0]        ms_count_ff, ms_count_in;
   logic [SLOT_COUNT-1:0]   active_ff, active_in;
   logic [OP_W-1:0]         op_ff, op_in;
   logic [TAG_BITS-1:0]     tag_ff, tag_in;
   logic [DELAY_W-1:0]      delay_ff, delay_in;
   logic [DELAY_W-1:0]      period_ff, period_in;
   logic [IDX_W-1:0]        ev_idx_ff, ev_idx_in;
   logic                    pend_valid_ff, pend_valid_in;
   res_type                 pend_ff, pend_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   res_type                 rsp_ff, rsp_in;
   logic [NOW_W-1:0]        rsp_now_ff, rsp_now_in;

   logic [ENT_W-1:0]        mem [SLOT_COUNT];
   logic [ENT_W-1:0]        rd_data_ff;
   logic                    rd_en;
   logic [IDX_W-1:0]        rd_addr;
   logic                    wr_en;
   logic [ENT_W-1:0]        wr_data;

   logic                    accept;
   logic                    out_free;
   logic                    act_bit;
   logic                    hit;
   logic                    stall;
   logic                    last_slot;
   logic [NOW_W-1:0]        ent_expiry;
   logic [DELAY_W-1:0]      ent_period;
   logic [TAG_BITS-1:0]     ent_tag;
   logic [DELAY_W-1:0]      add_offset;
   logic [31:0]             in_tag_wide;
   logic [31:0]             ent_tag_wide;
   logic [31:0]             req_tag_wide;
   logic [31:0]             idx_wide;
   res_type                 fired_res;

   assign ent_tag    = rd_data_ff[TAG_BITS-1:0];
   assign ent_period = rd_data_ff[PER_LSB +: DELAY_W];
   assign ent_expiry = rd_data_ff[EXP_LSB +: NOW_W];

   assign in_tag_wide  = {16'b0, req_tdata[15:0]};
   assign ent_tag_wide = 32'(ent_tag);
   assign req_tag_wide = 32'(tag_ff);
   assign idx_wide     = 32'(ev_idx_ff);
   assign add_offset   = (delay_ff != '0) ? delay_ff : period_ff;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign act_bit    = active_ff[ev_idx_ff];
   assign last_slot  = (ev_idx_ff == LAST_IDX);

   always_comb begin
      case (op_ff)
         OP_TICK:   hit = act_bit && (ent_expiry <= ms_count_ff);
         OP_ADD:    hit = !act_bit;
         OP_CANCEL: hit = act_bit && (ent_tag == tag_ff);
         default:   hit = 1'b0;
      endcase
   end

   assign stall = (state_ff == S_SCAN) && hit && (op_ff == OP_TICK)
                  && pend_valid_ff && !out_free;

   assign fired_res = '{kind: K_FIRED, tag: ent_tag_wide[15:0], slot: idx_wide[5:0],
                        found: 1'b0, last: 1'b0};

   always_comb begin
      state_in      = state_ff;
      ms_count_in   = ms_count_ff;
      active_in     = active_ff;
      op_in         = op_ff;
      tag_in        = tag_ff;
      delay_in      = delay_ff;
      period_in     = period_ff;
      ev_idx_in     = ev_idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      rsp_now_in    = rsp_now_ff;
      rd_en         = 1'b0;
      rd_addr       = ev_idx_ff + 1'b1;
      wr_en         = 1'b0;
      wr_data       = {ms_count_ff + NOW_W'(add_offset), period_ff, tag_ff};

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = req_tuser;
               tag_in    = in_tag_wide[TAG_BITS-1:0];
               delay_in  = req_tdata[47:16];
               period_in = req_tdata[79:48];
               if (req_tuser == OP_TICK) begin
                  ms_count_in = ms_count_ff + 1'b1;
               end
               if (req_tuser == OP_TICK || req_tuser == OP_ADD ||
                   req_tuser == OP_CANCEL) begin
                  rd_en     = 1'b1;
                  rd_addr   = '0;
                  ev_idx_in = '0;
                  state_in  = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (!stall) begin
               if (hit) begin
                  case (op_ff)
                     OP_TICK: begin
                        if (ent_period != '0) begin
                           wr_en   = 1'b1;
                           wr_data = {ms_count_ff + NOW_W'(ent_period), ent_period, ent_tag};
                        end else begin
                           active_in[ev_idx_ff] = 1'b0;
                        end
                        if (pend_valid_ff) begin
                           rsp_valid_in = 1'b1;
                           rsp_in       = pend_ff;
                           rsp_now_in   = ms_count_ff;
                        end
                        pend_valid_in = 1'b1;
                        pend_in       = fired_res;
                     end
                     OP_ADD: begin
                        wr_en                = 1'b1;
                        active_in[ev_idx_ff] = 1'b1;
                        pend_valid_in        = 1'b1;
                        pend_in              = '{kind: K_ADDED, tag: req_tag_wide[15:0],
                                                 slot: idx_wide[5:0], found: 1'b0,
                                                 last: 1'b1};
                     end
                     OP_CANCEL: begin
                        active_in[ev_idx_ff] = 1'b0;
                        pend_valid_in        = 1'b1;
                        pend_in              = '{kind: K_CANCEL, tag: req_tag_wide[15:0],
                                                 slot: idx_wide[5:0], found: 1'b1,
                                                 last: 1'b1};
                     end
                     default: begin
                     end
                  endcase
               end
               if ((hit && op_ff != OP_TICK) || last_slot) begin
                  state_in = S_FLUSH;
               end else begin
                  rd_en     = 1'b1;
                  ev_idx_in = rd_addr;
               end
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_now_in    = ms_count_ff;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
               if (pend_valid_ff) begin
                  rsp_in      = pend_ff;
                  rsp_in.last = 1'b1;
               end else begin
                  case (op_ff)
                     OP_TICK:  rsp_in = '{kind: K_NONE, tag: '0, slot: '0,
                                          found: 1'b0, last: 1'b1};
                     OP_ADD:   rsp_in = '{kind: K_FULL, tag: req_tag_wide[15:0],
                                          slot: '0, found: 1'b0, last: 1'b1};
                     default:  rsp_in = '{kind: K_CANCEL, tag: req_tag_wide[15:0],
                                          slot: '0, found: 1'b0, last: 1'b1};
                  endcase
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ms_count_ff   <= '0;
         active_ff     <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ms_count_ff   <= ms_count_in;
         active_ff     <= active_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      tag_ff     <= tag_in;
      delay_ff   <= delay_in;
      period_ff  <= period_in;
      ev_idx_ff  <= ev_idx_in;
      pend_ff    <= pend_in;
      rsp_ff     <= rsp_in;
      rsp_now_ff <= rsp_now_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[ev_idx_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {1'b0, rsp_now_ff, rsp_ff.found, rsp_ff.slot, rsp_ff.tag};

`ifndef ASSERT_OFF
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !pend_valid_ff)
      else $error("pending result left over in idle");

   a_tick_count: assert property (@(posedge clock) disable iff (reset)
      accept && req_tuser == OP_TICK |=> ms_count_ff == $past(ms_count_ff) + 1'b1)
      else $error("tick did not advance the counter");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !(accept && req_tuser == OP_TICK) |=> $stable(ms_count_ff))
      else $error("counter moved without a tick");

   a_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff == S_SCAN && !stall)
      else $error("slot write outside the scan");
`endif

endmodule

/* tb/timer_event_table_checker.sv */
// ----------------------------------------------------------------------------
// timer_event_table_checker
// Watches both streams of the timer event table. Every accepted request
// updates a private copy of the counter and slot table and queues the
// results that item must produce; every accepted result is compared field
// by field against the oldest queued one.
// ----------------------------------------------------------------------------
module timer_event_table_checker #(
   parameter int SLOT_COUNT = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [tel_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [tel_pkg::OP_W-1:0]       req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [tel_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic [tel_pkg::KIND_W-1:0]     rsp_tuser,
   input  logic                           rsp_tlast,
   output int                             mismatch_count,
   output int                             awaited_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import tel_pkg::*;

   typedef struct packed {
      kind_type          kind;
      logic [TAG_W-1:0]  tag;
      logic [SLOT_W-1:0] slot;
      logic              found;
      logic [NOW_W-1:0]  now;
      logic              last;
   } timer_result_type;

   timer_result_type   awaited_results[$];
   logic [NOW_W-1:0]   clock_ms;
   logic               slot_busy[SLOT_COUNT];
   logic [NOW_W-1:0]   due_ms[SLOT_COUNT];
   logic [DELAY_W-1:0] reload_ms[SLOT_COUNT];
   logic [TAG_W-1:0]   owner_tag[SLOT_COUNT];

   initial begin
      mismatch_count = 0;
      awaited_count  = 0;
   end

   function automatic void await_result(kind_type kind, logic [TAG_W-1:0] tag, int slot,
                                        logic found, logic last);
      timer_result_type r;
      r.kind  = kind;
      r.tag   = tag;
      r.slot  = SLOT_W'(slot);
      r.found = found;
      r.now   = clock_ms;
      r.last  = last;
      awaited_results.push_back(r);
   endfunction

   function automatic void apply_timer_item(logic [OP_W-1:0] op, logic [TAG_W-1:0] tag,
                                            logic [DELAY_W-1:0] delay,
                                            logic [DELAY_W-1:0] period);
      timer_result_type r;
      int               fired;
      int               hit;
      fired = 0;
      hit   = -1;
      case (op)
         OP_TICK: begin
            clock_ms = clock_ms + 64'd1;
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (slot_busy[i] && clock_ms >= due_ms[i]) begin
                  await_result(K_FIRED, owner_tag[i], i, 1'b0, 1'b0);
                  fired++;
                  if (reload_ms[i] != '0) begin
                     due_ms[i] = clock_ms + NOW_W'(reload_ms[i]);
                  end else begin
                     slot_busy[i] = 1'b0;
                  end
               end
            end
            if (fired == 0) begin
               await_result(K_NONE, '0, 0, 1'b0, 1'b1);
            end else begin
               r = awaited_results.pop_back();
               r.last = 1'b1;
               awaited_results.push_back(r);
            end
         end
         OP_ADD: begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (hit < 0 && !slot_busy[i]) hit = i;
            end
            if (hit < 0) begin
               await_result(K_FULL, tag, 0, 1'b0, 1'b1);
            end else begin
               slot_busy[hit] = 1'b1;
               due_ms[hit]    = clock_ms + NOW_W'((delay != '0) ? delay : period);
               reload_ms[hit] = period;
               owner_tag[hit] = tag;
               await_result(K_ADDED, tag, hit, 1'b0, 1'b1);
            end
         end
         OP_CANCEL: begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (hit < 0 && slot_busy[i] && owner_tag[i] == tag) hit = i;
            end
            if (hit < 0) begin
               await_result(K_CANCEL, tag, 0, 1'b0, 1'b1);
            end else begin
               slot_busy[hit] = 1'b0;
               await_result(K_CANCEL, tag, hit, 1'b1, 1'b1);
            end
         end
         default: begin
         end
      endcase
   endfunction

   function automatic void check_field(string field, logic [NOW_W-1:0] want,
                                       logic [NOW_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      timer_result_type want;
      if (reset) begin
         clock_ms = '0;
         for (int i = 0; i < SLOT_COUNT; i++) slot_busy[i] = 1'b0;
         awaited_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_results.size() == 0) begin
               $error("result with nothing expected: kind %0d", rsp_tuser);
               mismatch_count++;
            end else begin
               want = awaited_results.pop_front();
               check_field("result_kind", NOW_W'(want.kind), NOW_W'(rsp_tuser));
               check_field("event_tag_out", NOW_W'(want.tag), NOW_W'(rsp_tdata[15:0]));
               check_field("slot_index", NOW_W'(want.slot), NOW_W'(rsp_tdata[21:16]));
               check_field("found", NOW_W'(want.found), NOW_W'(rsp_tdata[22]));
               check_field("now_ms", want.now, rsp_tdata[86:23]);
               check_field("last", NOW_W'(want.last), NOW_W'(rsp_tlast));
            end
         end
         if (req_tvalid && req_tready) begin
            apply_timer_item(req_tuser, req_tdata[15:0], req_tdata[47:16], req_tdata[79:48]);
         end
      end
      awaited_count <= awaited_results.size();
   end

endmodule

/* tb/timer_event_table_test.sv */
// ----------------------------------------------------------------------------
// timer_event_table_test
// Drives ticks, adds, cancels and unknown operations into the timer event
// table: a directed opening, then random traffic with a table-filling burst,
// under three idling patterns. The checker beside the block judges results.
// ----------------------------------------------------------------------------
module timer_event_table_test;
   timeunit 1ns;
   timeprecision 1ps;
   import tel_pkg::*;

   localparam int              SLOT_COUNT   = 64;
   localparam int              LIMIT_CYCLES = 1_000_000;
   localparam logic [OP_W-1:0] OP_UNKNOWN   = 2'd3;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [OP_W-1:0]       req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;
   logic                  rsp_tlast;

   int mismatch_count;
   int awaited_count;
   int cycle_count  = 0;
   int req_idle_pct = 6;
   int rsp_idle_pct = 87;

   timer_event_table #(
      .SLOT_COUNT(SLOT_COUNT),
      .TAG_BITS  (TAG_W)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   timer_event_table_checker #(
      .SLOT_COUNT(SLOT_COUNT)
   ) table_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .mismatch_count(mismatch_count),
      .awaited_count (awaited_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_item(logic [OP_W-1:0] op, logic [TAG_W-1:0] tag,
                            logic [DELAY_W-1:0] delay, logic [DELAY_W-1:0] period);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {period, delay, tag};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_random_item(int add_pct, int cancel_pct);
      int                 roll;
      logic [OP_W-1:0]    op;
      logic [TAG_W-1:0]   tag;
      logic [DELAY_W-1:0] delay;
      logic [DELAY_W-1:0] period;
      roll = $urandom_range(99);
      if (roll < 4) op = OP_UNKNOWN;
      else if (roll < 4 + add_pct) op = OP_ADD;
      else if (roll < 4 + add_pct + cancel_pct) op = OP_CANCEL;
      else op = OP_TICK;
      tag = ($urandom_range(9) < 7) ? TAG_W'($urandom_range(7)) : TAG_W'($urandom);
      roll = $urandom_range(9);
      if (roll < 4) delay = '0;
      else if (roll < 8) delay = $urandom_range(8, 1);
      else delay = $urandom;
      roll = $urandom_range(9);
      if (roll < 5) period = '0;
      else if (roll < 8) period = $urandom_range(6, 1);
      else period = $urandom;
      send_item(op, tag, delay, period);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(OP_TICK, '0, '0, '0);
      send_item(OP_CANCEL, '0, '0, '0);
      send_item(OP_UNKNOWN, '1, '1, '1);
      send_item(OP_ADD, 16'hFFFF, '0, '0);
      send_item(OP_ADD, 16'h0000, '1, '1);
      send_item(OP_ADD, 16'h1234, 32'd2, 32'd3);
      send_item(OP_ADD, 16'h1234, 32'd1, '0);
      send_item(OP_CANCEL, 16'h1234, '0, '0);
      repeat (3) send_item(OP_TICK, '0, '0, '0);
      send_item(OP_ADD, 16'hA5A5, '0, 32'd1);
      send_item(OP_ADD, 16'h5A5A, 32'd1, '0);
      send_item(OP_ADD, 16'h0F0F, 32'd1, 32'd2);
      repeat (2) send_item(OP_TICK, '1, '1, '1);
      send_item(OP_CANCEL, 16'hA5A5, '1, '1);
      send_item(OP_ADD, 16'h00FF, '0, 32'hFFFF_FFFF);
      send_item(OP_CANCEL, 16'h0000, '0, '0);
      send_item(OP_CANCEL, 16'h0F0F, '0, '0);
      send_item(OP_TICK, '0, '0, '0);

      repeat (40) send_random_item(45, 12);

      req_idle_pct = 87;
      rsp_idle_pct = 6;
      repeat (66) begin
         send_item(OP_ADD, ($urandom_range(1) != 0) ? TAG_W'($urandom_range(7)) : TAG_W'($urandom),
                   32'h8000_0000 | $urandom, $urandom);
      end
      repeat (25) send_random_item(30, 40);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      repeat (30) send_random_item(35, 20);

      req_tvalid <= 1'b0;
      do @(posedge clock); while (awaited_count != 0);
      repeat (SLOT_COUNT + 8) @(posedge clock);

      if (mismatch_count == 0 && awaited_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* timer_event_table.f */
rtl/core/tel_pkg.sv
rtl/core/timer_event_table.sv
tb/timer_event_table_checker.sv
tb/timer_event_table_test.sv
